// ----- hdl/fpa_pkg.sv -----
// Shared types and constants for the partition allocator.
// Holds the controller states, the command and status structs and the register codes.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int AMOUNT_W   = 16;
    localparam int PIDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'd1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [4:0] COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic load_wr;
        logic scan_rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hdl/fit_partition_allocator.sv -----
// Partition allocator with first, best and worst fit placement.
// A load item writes the free size memory and gives no result. A request item scans the
// partitions in use, then commits; the commit waits while the result register is occupied,
// and no new item is taken before the commit. The scan reads one partition per cycle. With
// no partitions in use a request skips to commit. Reset clears control and configuration
// only; the free size memory holds nothing valid until each entry is loaded.
`timescale 1ns / 1ps

module fit_partition_allocator
    import fpa_pkg::*;
#(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [PIDX_W-1:0]     i_partition_index,
    input  logic [AMOUNT_W-1:0]   i_amount,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_granted,
    output logic [PIDX_W-1:0]     o_chosen_partition,
    output logic [AMOUNT_W-1:0]   o_space_left
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fpa_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    fpa_datapath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_dp_cmd           (dp_cmd),
        .o_dp_stat          (dp_stat),
        .i_partition_index  (i_partition_index),
        .i_amount           (i_amount),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_granted          (o_granted),
        .o_chosen_partition (o_chosen_partition),
        .o_space_left       (o_space_left)
    );

endmodule

// ----- hdl/fpa_datapath.sv -----
// Datapath of the partition allocator: free size memory, scan counter, best candidate
// registers, configuration registers and the result register.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_datapath
    import fpa_pkg::*;
#(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_dp_cmd                i_dp_cmd,
    output t_dp_stat               o_dp_stat,
    input  logic [PIDX_W-1:0]      i_partition_index,
    input  logic [AMOUNT_W-1:0]    i_amount,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_granted,
    output logic [PIDX_W-1:0]      o_chosen_partition,
    output logic [AMOUNT_W-1:0]    o_space_left
);

    localparam int IDX_W = $clog2(PARTITIONS);
    localparam int CNT_W = $clog2(PARTITIONS + 1);
    localparam int CW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int VW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    logic [SIZE_BITS-1:0] r_mem [PARTITIONS];

    logic [1:0]            r_mode;
    logic [CFG_DATA_W-1:0] r_part_count;
    logic [IDX_W-1:0]      r_scan;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic [AMOUNT_W-1:0]   r_amount;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_BITS-1:0]  r_best_val;
    logic                  r_o_valid;
    logic                  r_granted;
    logic [PIDX_W-1:0]     r_chosen;
    logic [AMOUNT_W-1:0]   r_space;

    logic [CW-1:0]                 count_w;
    logic [CW-1:0]                 limit;
    logic [IDX_W+PIDX_W-1:0]       ld_idx_ext;
    logic [SIZE_BITS+AMOUNT_W-1:0] ld_wide;
    logic [SIZE_BITS-1:0]          ld_data;
    logic                          ld_in_range;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_wa;
    logic [SIZE_BITS-1:0]          mem_wd;
    logic [VW-1:0]                 amt_w;
    logic [VW-1:0]                 rd_w;
    logic                          fits;
    logic                          take;
    logic [SIZE_BITS-1:0]          rem;
    logic [VW-1:0]                 rem_w;
    logic [IDX_W+PIDX_W-1:0]       best_ext;

    assign count_w = CW'(r_part_count);
    assign limit   = (count_w > CW'(PARTITIONS)) ? CW'(PARTITIONS) : count_w;

    assign o_dp_stat.count_zero = (r_part_count == '0);
    assign o_dp_stat.scan_last  = ((CW'(r_scan) + CW'(1)) == limit);
    assign o_dp_stat.out_free   = !r_o_valid || i_out_ready;

    assign ld_idx_ext  = {{IDX_W{1'b0}}, i_partition_index};
    assign ld_in_range = (32'(i_partition_index) < PARTITIONS);
    assign ld_wide     = {{SIZE_BITS{1'b0}}, i_amount};
    assign ld_data     = (|(ld_wide >> SIZE_BITS)) ? {SIZE_BITS{1'b1}}
                                                   : ld_wide[SIZE_BITS-1:0];

    assign amt_w = VW'(r_amount);
    assign rd_w  = VW'(r_rd_data);
    assign fits  = (rd_w >= amt_w);
    assign rem   = r_best_val - amt_w[SIZE_BITS-1:0];
    assign rem_w = VW'(rem);
    assign best_ext = {{PIDX_W{1'b0}}, r_best_idx};

    always_comb begin
        take = 1'b0;
        if (r_rd_vld && fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else begin
                case (r_mode)
                    MODE_BEST:  take = (r_rd_data < r_best_val);
                    MODE_WORST: take = (r_rd_data > r_best_val);
                    default:    take = 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_best_idx;
        mem_wd = rem;
        if (i_dp_cmd.load_wr) begin
            mem_we = ld_in_range;
            mem_wa = ld_idx_ext[IDX_W-1:0];
            mem_wd = ld_data;
        end else if (i_dp_cmd.commit) begin
            mem_we = r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_dp_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_scan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_FIRST;
            r_part_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:   r_mode       <= i_cfg_data[1:0];
                CFG_PART_COUNT: r_part_count <= i_cfg_data;
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_dp_cmd.scan_rd;
            if (i_dp_cmd.start) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_dp_cmd.scan_rd) begin
                    r_scan <= r_scan + IDX_W'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_dp_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_amount <= i_amount;
        end
        if (i_dp_cmd.scan_rd) begin
            r_rd_idx <= r_scan;
        end
        if (take) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= r_rd_data;
        end
        if (i_dp_cmd.commit) begin
            r_granted <= r_found;
            r_chosen  <= r_found ? best_ext[PIDX_W-1:0] : '0;
            r_space   <= r_found ? rem_w[AMOUNT_W-1:0] : '0;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_granted          = r_granted;
    assign o_chosen_partition = r_chosen;
    assign o_space_left       = r_space;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.commit |=> r_o_valid)
        else $error("Result register not loaded after commit.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CW'(r_rd_idx) < limit))
        else $error("Scan read beyond the active partitions.");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.start |=> !r_found)
        else $error("Candidate flag survived the start of a request.");

endmodule

// ----- hdl/fpa_controller.sv -----
// Controller of the partition allocator: sequences loads, the partition scan and the commit.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_controller
    import fpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_cmd,
    output logic     o_in_ready,
    input  t_dp_stat i_dp_stat,
    output t_dp_cmd  o_dp_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_REQUEST)) begin
                    n_state = i_dp_stat.count_zero ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_dp_stat.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_dp_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_dp_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_dp_cmd.start   = accept && (i_cmd == CMD_REQUEST);
                o_dp_cmd.load_wr = accept && (i_cmd == CMD_LOAD);
            end
            ST_SCAN: begin
                o_dp_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
                o_dp_cmd = '0;
            end
            ST_COMMIT: begin
                o_dp_cmd.commit = i_dp_stat.out_free;
            end
            default: o_dp_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_request_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_REQUEST) && !i_dp_stat.count_zero) |=> (r_state == ST_SCAN))
        else $error("Request did not start a scan.");

    a_no_scan_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.scan_rd |-> !i_dp_stat.count_zero)
        else $error("Scan issued with no partitions in use.");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.commit |-> i_dp_stat.out_free)
        else $error("Commit while the result register is still occupied.");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for fit_partition_allocator: directed and random load and request items
// under first, best and worst fit, checked against an in-bench model of the free size table.
// Depends on fpa_pkg and the fit_partition_allocator RTL.
`timescale 1ns / 1ps

module tb_top
    import fpa_pkg::*;
();

    localparam int N_PARTS       = 16;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [PIDX_W-1:0]   part;
        logic [AMOUNT_W-1:0] amount;
    } t_alloc_item;

    typedef struct packed {
        logic                granted;
        logic [PIDX_W-1:0]   part;
        logic [AMOUNT_W-1:0] left;
    } t_alloc_grant;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FIT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = CMD_LOAD;
    logic [PIDX_W-1:0]     i_partition_index = '0;
    logic [AMOUNT_W-1:0]   i_amount = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_granted;
    logic [PIDX_W-1:0]     o_chosen_partition;
    logic [AMOUNT_W-1:0]   o_space_left;

    t_alloc_item  stim_items[$];
    t_alloc_grant expected_grants[$];

    logic [AMOUNT_W-1:0] free_size [N_PARTS];
    logic [1:0]          fit_mode_q = MODE_FIRST;
    logic [4:0]          part_count_q = COUNT_RESET;

    int mismatches = 0;
    int loads_done = 0;
    int requests_done = 0;
    int grants_done = 0;
    int settings_used = 0;

    int gap_left = 0;
    int burst_left = 0;
    int sink_style = 0;
    int style_left = 0;
    int hold_left = 0;

    fit_partition_allocator #(
        .PARTITIONS(N_PARTS),
        .SIZE_BITS (AMOUNT_W)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_partition_index (i_partition_index),
        .i_amount          (i_amount),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted         (o_granted),
        .o_chosen_partition(o_chosen_partition),
        .o_space_left      (o_space_left)
    );

    always #5 i_clk = ~i_clk;

    // Applies one accepted item to the free size table and, for a request, queues the allocation outcome.
    function automatic void take_item(input t_alloc_item it);
        t_alloc_grant res;
        int           limit;
        int           pick;
        bit           found;
        bit           stop;
        if (it.cmd == CMD_LOAD) begin
            free_size[it.part] = it.amount;
            loads_done++;
        end else begin
            limit = (part_count_q > N_PARTS) ? N_PARTS : int'(part_count_q);
            found = 1'b0;
            stop  = 1'b0;
            pick  = 0;
            for (int j = 0; j < limit; j++) begin
                if (!stop && free_size[j] >= it.amount) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                        stop  = (fit_mode_q != MODE_BEST) && (fit_mode_q != MODE_WORST);
                    end else if (fit_mode_q == MODE_BEST && free_size[j] < free_size[pick]) begin
                        pick = j;
                    end else if (fit_mode_q == MODE_WORST && free_size[j] > free_size[pick]) begin
                        pick = j;
                    end
                end
            end
            if (found) begin
                free_size[pick] = free_size[pick] - it.amount;
                res = t_alloc_grant'{1'b1, pick[PIDX_W-1:0], free_size[pick]};
                grants_done++;
            end else begin
                res = '0;
            end
            expected_grants.push_back(res);
            requests_done++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        if (idx == CFG_FIT_MODE) begin
            fit_mode_q = 2'(value);
        end else begin
            part_count_q = 5'(value);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_policy(input logic [1:0] mode, input int count);
        write_reg(CFG_FIT_MODE, mode);
        write_reg(CFG_PART_COUNT, count);
        settings_used++;
    endtask

    task automatic push_item(input logic cmd, input int part, input int amount);
        stim_items.push_back(t_alloc_item'{cmd, PIDX_W'(part), AMOUNT_W'(amount)});
    endtask

    // Blocks until every queued item is accepted and every outcome has been returned.
    task automatic drain_phase();
        while (stim_items.size() != 0 || i_in_valid || expected_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_alloc_item random_item(input int span);
        t_alloc_item it;
        int          r;
        it.cmd = ($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_REQUEST;
        it.part = ($urandom_range(0, 9) < 7) ? PIDX_W'($urandom_range(0, span - 1))
                                             : PIDX_W'($urandom_range(0, N_PARTS - 1));
        r = $urandom_range(0, 19);
        if (it.cmd == CMD_LOAD) begin
            if (r < 5) it.amount = AMOUNT_W'($urandom);
            else if (r < 15) it.amount = AMOUNT_W'($urandom_range(1000, 65535));
            else if (r < 18) it.amount = AMOUNT_W'($urandom_range(0, 255));
            else it.amount = (r == 18) ? '0 : '1;
        end else begin
            if (r < 8) it.amount = AMOUNT_W'($urandom_range(0, 255));
            else if (r < 14) it.amount = AMOUNT_W'($urandom_range(0, 4095));
            else if (r < 18) it.amount = AMOUNT_W'($urandom);
            else it.amount = (r == 18) ? '0 : '1;
        end
        return it;
    endfunction

    always @(posedge i_clk) begin : feed_proc
        t_alloc_item nxt;
        logic        issue;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                take_item(t_alloc_item'{i_cmd, i_partition_index, i_amount});
            end
            issue = 1'b0;
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (stim_items.size() != 0) begin
                nxt   = stim_items.pop_front();
                issue = 1'b1;
                i_cmd             <= nxt.cmd;
                i_partition_index <= nxt.part;
                i_amount          <= nxt.amount;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            i_in_valid <= issue;
        end
    end

    always @(posedge i_clk) begin : sink_proc
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                sink_style <= $urandom_range(0, 2);
                style_left <= $urandom_range(50, 300);
            end else begin
                style_left <= style_left - 1;
            end
            case (sink_style)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (hold_left != 0) begin
                        hold_left   <= hold_left - 1;
                        i_out_ready <= 1'b0;
                    end else begin
                        hold_left   <= $urandom_range(1, 30);
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_alloc_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result granted=%0b partition=%0d left=%0d",
                                          o_granted, o_chosen_partition, o_space_left));
            end else begin
                want = expected_grants.pop_front();
                if (o_granted !== want.granted) begin
                    report_mismatch($sformatf("granted %0b, expected %0b",
                                              o_granted, want.granted));
                end
                if (o_chosen_partition !== want.part) begin
                    report_mismatch($sformatf("chosen_partition %0d, expected %0d",
                                              o_chosen_partition, want.part));
                end
                if (o_space_left !== want.left) begin
                    report_mismatch($sformatf("space_left %0d, expected %0d",
                                              o_space_left, want.left));
                end
            end
        end
    end

    initial begin : main_proc
        logic [AMOUNT_W-1:0] start_sizes [N_PARTS];
        logic [1:0]          mode;
        int                  count;
        int                  span;
        int                  sel;
        int                  phase_len;
        int                  random_sent;
        start_sizes = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'd300, 16'd300, 16'd500,
                        16'd50, 16'h7FFF, 16'h1234, 16'd300, 16'hAAAA, 16'h5555, 16'h0002,
                        16'd300, 16'hFFFE};
        random_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every partition is loaded before the first request so that no scan meets an empty entry.
        set_policy(MODE_FIRST, 16);
        for (int p = 0; p < N_PARTS; p++) begin
            push_item(CMD_LOAD, p, start_sizes[p]);
        end
        push_item(CMD_REQUEST, 9, 0);
        push_item(CMD_REQUEST, 0, 16'hFFFF);
        push_item(CMD_REQUEST, 15, 16'hFFFF);
        push_item(CMD_REQUEST, 0, 1);
        push_item(CMD_REQUEST, 0, 400);
        drain_phase();

        set_policy(MODE_BEST, 16);
        push_item(CMD_REQUEST, 0, 300);
        push_item(CMD_REQUEST, 0, 0);
        push_item(CMD_REQUEST, 0, 300);
        drain_phase();

        set_policy(MODE_WORST, 16);
        push_item(CMD_REQUEST, 0, 0);
        push_item(CMD_REQUEST, 0, 16'hFFFE);
        push_item(CMD_REQUEST, 0, 100);
        drain_phase();

        set_policy(MODE_SPARE, 16);
        push_item(CMD_REQUEST, 0, 2);
        drain_phase();

        set_policy(MODE_FIRST, 0);
        push_item(CMD_REQUEST, 0, 0);
        drain_phase();

        set_policy(MODE_BEST, 31);
        push_item(CMD_REQUEST, 0, 1);
        drain_phase();

        set_policy(MODE_WORST, 1);
        push_item(CMD_REQUEST, 0, 0);
        push_item(CMD_REQUEST, 0, 16'h8000);
        push_item(CMD_LOAD, 0, 16'hFFFF);
        push_item(CMD_REQUEST, 0, 16'hFFFF);
        drain_phase();

        while (random_sent < RANDOM_ITEMS) begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
            sel = $urandom_range(0, 19);
            if (sel == 0) count = 0;
            else if (sel == 1) count = $urandom_range(17, 31);
            else if (sel < 5) count = 16;
            else count = $urandom_range(1, 16);
            span = (count == 0 || count > N_PARTS) ? N_PARTS : count;
            set_policy(mode, count);
            phase_len = $urandom_range(40, 120);
            for (int k = 0; k < phase_len; k++) begin
                stim_items.push_back(random_item(span));
            end
            random_sent += phase_len;
            drain_phase();
        end

        $display("Covered %0d loads and %0d requests under %0d register settings.",
                 loads_done, requests_done, settings_used);
        $display("Requests granted: %0d, refused: %0d.",
                 grants_done, requests_done - grants_done);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
